/* rtl/core/cprg_pkg.sv */
// Shared types, constants and helpers for the primary ray generator.
`default_nettype none

package cprg_pkg;

    localparam int COMP_W               = 21;
    localparam int VEC_W                = 3 * COMP_W;
    localparam int STEP_W               = 24;
    localparam int COORD_W              = 12;
    localparam int DIR_W                = 16;
    localparam int PIXEL_INDEX_BITS_DEF = 12;
    localparam int APB_AW               = 6;
    localparam int APB_DW               = 64;
    localparam int SUM_W                = 62;
    localparam int ROOT_W               = 31;
    localparam int QUO_W                = 15;
    localparam int DIR_ONE              = 16384;

    // Register indexes, taken from paddr[5:3]
    localparam logic [2:0] REG_CAM_POS  = 3'd0;
    localparam logic [2:0] REG_TOP_LEFT = 3'd1;
    localparam logic [2:0] REG_RIGHT    = 3'd2;
    localparam logic [2:0] REG_UP       = 3'd3;
    localparam logic [2:0] REG_PIX_W    = 3'd4;
    localparam logic [2:0] REG_PIX_H    = 3'd5;

    // Sub-pixel offsets in quarters of a pixel
    localparam logic [1:0] Q_LOW    = 2'd1;
    localparam logic [1:0] Q_CENTER = 2'd2;
    localparam logic [1:0] Q_HIGH   = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [1:0]              sample_index;
        logic                    last_ray;
    } ray_t;

    typedef struct packed {
        logic [1:0] idx;
        logic       last;
    } tag_t;

    function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] v, input int i);
        return $signed(v[COMP_W*i +: COMP_W]);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/camera_primary_ray_generator.sv */
// Pinhole camera primary ray generator with optional 2x2 supersampling.
//
// pixel channel: one transaction per pixel (mode, col, row). ray channel: one
// transaction per ray, carrying the unit direction in Q1.14, the sample index
// and a last_ray flag. Mode 0 yields one centre ray; mode 1 yields four rays.
// Both channels use valid/stall; configuration goes through the APB port at
// byte address 8*index and must be written while the block is idle; the user
// is bound to this, as the block itself does not enforce it.
//
// The datapath is a 35-stage pipeline (multiply, sum, normalize, square, a
// 16-stage square root and an 8-stage divider in three lanes). Throughput:
// one ray per cycle while ray_stall does not hold the pipeline; the sample
// sequencer at the head takes the next pixel as the last ray of one advances.
//
// Reset clears all valid bits and the configuration registers to zero.
// When ray_stall is high with a ray waiting, the whole pipeline holds; the
// input register still takes one new pixel if idle; nothing is lost or repeated.
`default_nettype none

module camera_primary_ray_generator #(
    parameter int PIXEL_INDEX_BITS = cprg_pkg::PIXEL_INDEX_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cprg_pkg::APB_AW-1:0]   paddr,
    input  wire logic [cprg_pkg::APB_DW-1:0]   pwdata,
    output logic      [cprg_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          pixel_valid,
    output logic                               pixel_stall,
    input  wire cprg_pkg::pixel_t              pixel,
    output logic                               ray_valid,
    input  wire logic                          ray_stall,
    output cprg_pkg::ray_t                     ray
);
    import cprg_pkg::*;

    localparam int PB      = PIXEL_INDEX_BITS;
    localparam int CW      = PB + 2;
    localparam int UW      = PB + STEP_W;
    localparam int PW      = UW + 1 + COMP_W;
    localparam int TRIAL_W = SUM_W + 1;
    localparam int SQ_ST   = (ROOT_W + 1) / 2;
    localparam int DV_ST   = (QUO_W + 1) / 2;
    localparam int NUM_W   = ROOT_W + QUO_W - 1;

    // ---------------- configuration ----------------
    logic [VEC_W-1:0]  cam_pos_reg, top_left_reg, right_reg, up_reg;
    logic [STEP_W-1:0] pix_w_reg, pix_h_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_pos_reg  <= '0;
            top_left_reg <= '0;
            right_reg    <= '0;
            up_reg       <= '0;
            pix_w_reg    <= '0;
            pix_h_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[5:3])
                REG_CAM_POS:  cam_pos_reg  <= pwdata[VEC_W-1:0];
                REG_TOP_LEFT: top_left_reg <= pwdata[VEC_W-1:0];
                REG_RIGHT:    right_reg    <= pwdata[VEC_W-1:0];
                REG_UP:       up_reg       <= pwdata[VEC_W-1:0];
                REG_PIX_W:    pix_w_reg    <= pwdata[STEP_W-1:0];
                REG_PIX_H:    pix_h_reg    <= pwdata[STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_CAM_POS:  prdata = APB_DW'(cam_pos_reg);
            REG_TOP_LEFT: prdata = APB_DW'(top_left_reg);
            REG_RIGHT:    prdata = APB_DW'(right_reg);
            REG_UP:       prdata = APB_DW'(up_reg);
            REG_PIX_W:    prdata = APB_DW'(pix_w_reg);
            REG_PIX_H:    prdata = APB_DW'(pix_h_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- sample sequencer ----------------
    logic       adv;
    pixel_t     item_reg;
    logic       busy_reg;
    logic [1:0] cnt_reg;
    logic       last_sample;
    logic       pix_acc;

    assign adv         = !(ray_valid && ray_stall);
    assign last_sample = !item_reg.mode || (cnt_reg == 2'd3);
    assign pixel_stall = busy_reg && !(adv && last_sample);
    assign pix_acc     = pixel_valid && !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (pix_acc)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (adv && busy_reg)
        begin
            if (last_sample)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
            item_reg <= pixel;
    end

    // ---------------- stage 0: sample coordinates in quarters ----------------
    logic          s0_valid_reg;
    logic [CW-1:0] s0_cu_reg, s0_cv_reg;
    tag_t          s0_tag_reg;
    logic [1:0]    qu, qv;

    always_comb
    begin
        if (!item_reg.mode)
        begin
            qu = Q_CENTER;
            qv = Q_CENTER;
        end
        else
        begin
            qu = cnt_reg[0] ? Q_HIGH : Q_LOW;
            qv = cnt_reg[1] ? Q_HIGH : Q_LOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= busy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_cu_reg       <= {PB'(item_reg.col), qu};
            s0_cv_reg       <= {PB'(item_reg.row), qv};
            s0_tag_reg.idx  <= item_reg.mode ? cnt_reg : 2'd0;
            s0_tag_reg.last <= last_sample;
        end
    end

    // ---------------- stage 1: plane offsets u, v ----------------
    logic                 s1_valid_reg;
    logic [UW-1:0]        s1_u_reg, s1_v_reg;
    tag_t                 s1_tag_reg;
    logic [CW+STEP_W-1:0] u_prod, v_prod;

    assign u_prod = s0_cu_reg * pix_w_reg;
    assign v_prod = s0_cv_reg * pix_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_u_reg   <= u_prod[CW+STEP_W-1:2];
            s1_v_reg   <= v_prod[CW+STEP_W-1:2];
            s1_tag_reg <= s0_tag_reg;
        end
    end

    // ---------------- stage 2: axis products ----------------
    logic                      s2_valid_reg;
    logic signed [PW-1:0]      s2_pr_reg [3];
    logic signed [PW-1:0]      s2_pv_reg [3];
    logic signed [COMP_W:0]    s2_base_reg [3];
    tag_t                      s2_tag_reg;
    logic signed [PW-1:0]      pr_next [3];
    logic signed [PW-1:0]      pv_next [3];
    logic signed [COMP_W:0]    base_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pr_next[i]   = $signed({1'b0, s1_u_reg}) * comp(right_reg, i);
            pv_next[i]   = $signed({1'b0, s1_v_reg}) * comp(up_reg, i);
            base_next[i] = (COMP_W+1)'(comp(top_left_reg, i))
                         - (COMP_W+1)'(comp(cam_pos_reg, i));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pr_reg   <= pr_next;
            s2_pv_reg   <= pv_next;
            s2_base_reg <= base_next;
            s2_tag_reg  <= s1_tag_reg;
        end
    end

    // ---------------- stage 3: difference vector ----------------
    logic               s3_valid_reg;
    logic signed [63:0] s3_d_reg [3];
    tag_t               s3_tag_reg;
    logic signed [63:0] d_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            d_next[i] = (64'(s2_base_reg[i]) <<< 20) + 64'(s2_pr_reg[i]) - 64'(s2_pv_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_d_reg   <= d_next;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    // ---------------- stage 4: combined magnitude bits ----------------
    // The OR of the magnitudes has the same bit length as the largest one.
    logic               s4_valid_reg;
    logic signed [63:0] s4_d_reg [3];
    logic [62:0]        s4_m_reg;
    tag_t               s4_tag_reg;
    logic [62:0]        m_next;

    always_comb
    begin
        logic signed [63:0] mg;
        m_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            mg     = s3_d_reg[i][63] ? -s3_d_reg[i] : s3_d_reg[i];
            m_next = m_next | mg[62:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_d_reg   <= s3_d_reg;
            s4_m_reg   <= m_next;
            s4_tag_reg <= s3_tag_reg;
        end
    end

    // ---------------- stage 5: bit length ----------------
    logic               s5_valid_reg;
    logic signed [63:0] s5_d_reg [3];
    logic [6:0]         s5_len_reg;
    logic               s5_zero_reg;
    tag_t               s5_tag_reg;
    logic [6:0]         len_next;

    always_comb
    begin
        len_next = '0;
        for (int i = 0; i < 63; i++)
            if (s4_m_reg[i])
                len_next = 7'(i + 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (adv)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_d_reg    <= s4_d_reg;
            s5_len_reg  <= len_next;
            s5_zero_reg <= (s4_m_reg == '0);
            s5_tag_reg  <= s4_tag_reg;
        end
    end

    // ---------------- stage 6: normalize to [2^29, 2^30) ----------------
    logic               s6_valid_reg;
    logic signed [31:0] s6_d_reg [3];
    logic               s6_zero_reg;
    tag_t               s6_tag_reg;
    logic signed [31:0] dn_next [3];

    always_comb
    begin
        logic signed [63:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            if (s5_len_reg > 7'd30)
                sh = s5_d_reg[i] >>> (s5_len_reg - 7'd30);
            else
                sh = s5_d_reg[i] <<< (7'd30 - s5_len_reg);
            dn_next[i] = sh[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (adv)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_d_reg    <= dn_next;
            s6_zero_reg <= s5_zero_reg;
            s6_tag_reg  <= s5_tag_reg;
        end
    end

    // ---------------- stage 7: squares ----------------
    logic               s7_valid_reg;
    logic signed [31:0] s7_d_reg [3];
    logic [SUM_W-1:0]   s7_sq_reg [3];
    logic               s7_zero_reg;
    tag_t               s7_tag_reg;
    logic [SUM_W-1:0]   sq_next [3];

    always_comb
    begin
        logic signed [63:0] p;
        for (int i = 0; i < 3; i++)
        begin
            p          = s6_d_reg[i] * s6_d_reg[i];
            sq_next[i] = p[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else if (adv)
            s7_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_d_reg    <= s6_d_reg;
            s7_sq_reg   <= sq_next;
            s7_zero_reg <= s6_zero_reg;
            s7_tag_reg  <= s6_tag_reg;
        end
    end

    // ---------------- square root: two result bits per stage ----------------
    // Entry 0 holds the sum of squares; entry k the state after k stages.
    logic               sq_valid_reg [SQ_ST+1];
    logic [SUM_W-1:0]   sq_rem_reg   [SQ_ST+1];
    logic [ROOT_W-1:0]  sq_root_reg  [SQ_ST+1];
    logic signed [31:0] sq_d_reg     [SQ_ST+1][3];
    logic               sq_zero_reg  [SQ_ST+1];
    tag_t               sq_tag_reg   [SQ_ST+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (adv)
            sq_valid_reg[0] <= s7_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0]  <= s7_sq_reg[0] + s7_sq_reg[1] + s7_sq_reg[2];
            sq_root_reg[0] <= '0;
            sq_d_reg[0]    <= s7_d_reg;
            sq_zero_reg[0] <= s7_zero_reg;
            sq_tag_reg[0]  <= s7_tag_reg;
        end
    end

    for (genvar gs = 0; gs < SQ_ST; gs++)
    begin : g_sqrt
        logic [SUM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            int                 b;
            logic [TRIAL_W-1:0] trial;
            rem_next  = sq_rem_reg[gs];
            root_next = sq_root_reg[gs];
            for (int j = 0; j < 2; j++)
            begin
                b = ROOT_W - 1 - 2 * gs - j;
                if (b >= 0)
                begin
                    trial = (TRIAL_W'(root_next) << (b + 1)) | (TRIAL_W'(1) << (2 * b));
                    if ({1'b0, rem_next} >= trial)
                    begin
                        rem_next  = rem_next - trial[SUM_W-1:0];
                        root_next = root_next | (ROOT_W'(1) << b);
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[gs+1] <= 1'b0;
            else if (adv)
                sq_valid_reg[gs+1] <= sq_valid_reg[gs];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[gs+1]  <= rem_next;
                sq_root_reg[gs+1] <= root_next;
                sq_d_reg[gs+1]    <= sq_d_reg[gs];
                sq_zero_reg[gs+1] <= sq_zero_reg[gs];
                sq_tag_reg[gs+1]  <= sq_tag_reg[gs];
            end
        end
    end

    // ---------------- divider: round(|d| * 16384 / L), two bits per stage ----
    logic               dv_valid_reg [DV_ST+1];
    logic [ROOT_W-1:0]  dv_rem_reg   [DV_ST+1][3];
    logic [QUO_W-1:0]   dv_nlo_reg   [DV_ST+1][3];
    logic [QUO_W-1:0]   dv_quo_reg   [DV_ST+1][3];
    logic               dv_neg_reg   [DV_ST+1][3];
    logic [ROOT_W-1:0]  dv_l_reg     [DV_ST+1];
    logic               dv_zero_reg  [DV_ST+1];
    tag_t               dv_tag_reg   [DV_ST+1];
    logic [NUM_W-1:0]   num_next     [3];

    // Numerator with the rounding half of L folded in
    always_comb
    begin
        logic signed [31:0] ad;
        for (int i = 0; i < 3; i++)
        begin
            ad = sq_d_reg[SQ_ST][i][31] ? -sq_d_reg[SQ_ST][i] : sq_d_reg[SQ_ST][i];
            num_next[i] = {ad[ROOT_W-1:0], (QUO_W-1)'(0)}
                        + NUM_W'(sq_root_reg[SQ_ST][ROOT_W-1:1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= sq_valid_reg[SQ_ST];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= ROOT_W'(num_next[i][NUM_W-1:QUO_W]);
                dv_nlo_reg[0][i] <= num_next[i][QUO_W-1:0];
                dv_quo_reg[0][i] <= '0;
                dv_neg_reg[0][i] <= sq_d_reg[SQ_ST][i][31];
            end
            dv_l_reg[0]    <= sq_root_reg[SQ_ST];
            dv_zero_reg[0] <= sq_zero_reg[SQ_ST];
            dv_tag_reg[0]  <= sq_tag_reg[SQ_ST];
        end
    end

    for (genvar gd = 0; gd < DV_ST; gd++)
    begin : g_div
        logic [ROOT_W-1:0] rem_next [3];
        logic [QUO_W-1:0]  quo_next [3];

        always_comb
        begin
            int                b;
            logic [ROOT_W:0]   t;
            t = '0;
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = dv_rem_reg[gd][i];
                quo_next[i] = dv_quo_reg[gd][i];
                for (int j = 0; j < 2; j++)
                begin
                    b = QUO_W - 1 - 2 * gd - j;
                    if (b >= 0)
                    begin
                        t = {rem_next[i], dv_nlo_reg[gd][i][b]};
                        if (t >= {1'b0, dv_l_reg[gd]})
                        begin
                            t           = t - {1'b0, dv_l_reg[gd]};
                            quo_next[i] = quo_next[i] | (QUO_W'(1) << b);
                        end
                        rem_next[i] = t[ROOT_W-1:0];
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[gd+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[gd+1] <= dv_valid_reg[gd];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[gd+1]  <= rem_next;
                dv_quo_reg[gd+1]  <= quo_next;
                dv_nlo_reg[gd+1]  <= dv_nlo_reg[gd];
                dv_neg_reg[gd+1]  <= dv_neg_reg[gd];
                dv_l_reg[gd+1]    <= dv_l_reg[gd];
                dv_zero_reg[gd+1] <= dv_zero_reg[gd];
                dv_tag_reg[gd+1]  <= dv_tag_reg[gd];
            end
        end
    end

    // ---------------- output register ----------------
    logic                    ray_valid_reg;
    ray_t                    ray_reg;
    logic signed [DIR_W-1:0] dir_next [3];

    always_comb
    begin
        logic signed [DIR_W-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            q = $signed({1'b0, dv_quo_reg[DV_ST][i]});
            if (dv_zero_reg[DV_ST])
                dir_next[i] = '0;
            else if (dv_neg_reg[DV_ST][i])
                dir_next[i] = -q;
            else
                dir_next[i] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ray_valid_reg <= 1'b0;
        else if (adv)
            ray_valid_reg <= dv_valid_reg[DV_ST];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ray_reg.dir_x        <= dir_next[0];
            ray_reg.dir_y        <= dir_next[1];
            ray_reg.dir_z        <= dir_next[2];
            ray_reg.sample_index <= dv_tag_reg[DV_ST].idx;
            ray_reg.last_ray     <= dv_tag_reg[DV_ST].last;
        end
    end

    assign ray_valid = ray_valid_reg;
    assign ray       = ray_reg;

endmodule

`default_nettype wire

/* rtl/core/cprg_checker.sv */
// Port-level checks for the primary ray generator, bound to the top level.
`default_nettype none

module cprg_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           ray_valid,
    input wire logic           ray_stall,
    input wire cprg_pkg::ray_t ray
);
    import cprg_pkg::*;

    localparam logic signed [DIR_W-1:0] DIR_MAX = DIR_W'(DIR_ONE);
    localparam logic signed [DIR_W-1:0] DIR_MIN = -DIR_W'(DIR_ONE);

    // Hold a stalled ray unchanged
    a_ray_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ray_valid && ray_stall |=> ray_valid && $stable(ray))
        else $error("ray changed while stalled");

    // A pixel ends on its centre ray or on the fourth supersample
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        ray_valid && ray.last_ray |-> ray.sample_index == 2'd0 || ray.sample_index == 2'd3)
        else $error("last ray with a middle sample index");

    a_fourth_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        ray_valid && ray.sample_index == 2'd3 |-> ray.last_ray)
        else $error("fourth sample not marked last");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        ray_valid |-> ray.dir_x <= DIR_MAX && ray.dir_x >= DIR_MIN
                   && ray.dir_y <= DIR_MAX && ray.dir_y >= DIR_MIN
                   && ray.dir_z <= DIR_MAX && ray.dir_z >= DIR_MIN)
        else $error("direction component beyond unit length");

endmodule

bind camera_primary_ray_generator cprg_checker u_cprg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray_valid (ray_valid),
    .ray_stall (ray_stall),
    .ray       (ray)
);

`default_nettype wire
